FILE: design/depth_pixel_backprojection_unit_macros.svh
// Assertion macros shared by the RTL of the depth back-projection block.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH

// Same-cycle implication.
`define DPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned PosW    = $clog2(MaxWidth);
  localparam int unsigned RowW    = $clog2(MaxHeight);
  localparam int unsigned FwW     = 13;
  localparam int unsigned MulAW   = 32;
  localparam int unsigned MulBW   = 28;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned KeptW   = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_RECIP_FX     = 3'd2,
    REG_RECIP_FY     = 3'd3,
    REG_RECIP_DSCALE = 3'd4,
    REG_MIN_DEPTH    = 3'd5,
    REG_MAX_DEPTH    = 3'd6,
    REG_FRAME_WIDTH  = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] CenterXRst  = 16'd5120;
  localparam logic [15:0] CenterYRst  = 16'd3840;
  localparam logic [23:0] RecipFRst   = 24'd32263;
  localparam logic [23:0] RecipDsRst  = 24'd16777;
  localparam logic [31:0] MinDepthRst = 32'd0;
  localparam logic [31:0] MaxDepthRst = 32'd655360;
  localparam logic [FwW-1:0] FwRst    = 13'd640;

  typedef struct packed {
    logic [15:0]    center_x;
    logic [15:0]    center_y;
    logic [23:0]    recip_focal_x;
    logic [23:0]    recip_focal_y;
    logic [23:0]    recip_depth_scale;
    logic [31:0]    min_depth;
    logic [31:0]    max_depth;
    logic [FwW-1:0] eff_width;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/dpb_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module dpb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_data_i,
  output dpb_pkg::cfg_t                 cfg_o
);

  logic [15:0]             center_x_q, center_y_q;
  logic [23:0]             recip_fx_q, recip_fy_q, recip_ds_q;
  logic [31:0]             min_depth_q, max_depth_q;
  logic [dpb_pkg::FwW-1:0] fw_q;
  logic [dpb_pkg::FwW-1:0] eff_width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= dpb_pkg::CenterXRst;
      center_y_q  <= dpb_pkg::CenterYRst;
      recip_fx_q  <= dpb_pkg::RecipFRst;
      recip_fy_q  <= dpb_pkg::RecipFRst;
      recip_ds_q  <= dpb_pkg::RecipDsRst;
      min_depth_q <= dpb_pkg::MinDepthRst;
      max_depth_q <= dpb_pkg::MaxDepthRst;
      fw_q        <= dpb_pkg::FwRst;
    end else if (cfg_we_i) begin
      unique case (dpb_pkg::cfg_idx_e'(cfg_index_i))
        dpb_pkg::REG_CENTER_X:     center_x_q  <= cfg_data_i[15:0];
        dpb_pkg::REG_CENTER_Y:     center_y_q  <= cfg_data_i[15:0];
        dpb_pkg::REG_RECIP_FX:     recip_fx_q  <= cfg_data_i[23:0];
        dpb_pkg::REG_RECIP_FY:     recip_fy_q  <= cfg_data_i[23:0];
        dpb_pkg::REG_RECIP_DSCALE: recip_ds_q  <= cfg_data_i[23:0];
        dpb_pkg::REG_MIN_DEPTH:    min_depth_q <= cfg_data_i;
        dpb_pkg::REG_MAX_DEPTH:    max_depth_q <= cfg_data_i;
        dpb_pkg::REG_FRAME_WIDTH:  fw_q        <= cfg_data_i[dpb_pkg::FwW-1:0];
        default:                   center_x_q  <= center_x_q;
      endcase
    end
  end

  // A width of zero behaves as one; anything above MaxWidth is clamped to MaxWidth.
  always_comb begin
    priority if (fw_q == '0) begin
      eff_width = dpb_pkg::FwW'(1);
    end else if (fw_q > dpb_pkg::FwW'(dpb_pkg::MaxWidth)) begin
      eff_width = dpb_pkg::FwW'(dpb_pkg::MaxWidth);
    end else begin
      eff_width = fw_q;
    end
  end

  assign cfg_o = '{
    center_x:          center_x_q,
    center_y:          center_y_q,
    recip_focal_x:     recip_fx_q,
    recip_focal_y:     recip_fy_q,
    recip_depth_scale: recip_ds_q,
    min_depth:         min_depth_q,
    max_depth:         max_depth_q,
    eff_width:         eff_width
  };

endmodule

`default_nettype wire

FILE: design/dpb_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module dpb_mul (
  input  logic                        clk_i,
  input  logic [dpb_pkg::MulAW-1:0]   a_i,
  input  logic [dpb_pkg::MulBW-1:0]   b_i,
  output logic [dpb_pkg::ProdW-1:0]   prod_o
);

  logic [dpb_pkg::ProdW-1:0] prod_d, prod_q;

  assign prod_d = dpb_pkg::ProdW'(a_i) * dpb_pkg::ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: design/depth_pixel_backprojection_unit.sv
// Depth pixel back-projection unit.
// Input channel: one beat per depth pixel in raster order (raw_depth_i, colour bytes,
// last_pixel_i), qualified by in_valid_i and held off by in_stall_o. The beat with
// last_pixel_i set closes the frame; column, row and point index restart at zero.
// Output channel: one beat per kept point (x, y, z, colour, point index), qualified by
// out_valid_o and held off by out_stall_i. Pixels whose z is outside (min, max] give
// no beat. Configuration: cfg_valid_i/cfg_ready_o write beats, cfg_index_i selects the
// register; cfg_ready_o is always high and writes belong between pixels.
// Timing: one 32x28 multiplier with a registered product does every multiplication and
// is used once for z, and three times per axis (focal scale, low and high halves).
// A pixel holds the input off from its beat until the sequencer is back in S_IDLE:
// through S_Z, S_ZCHK, the projection states S_PX to S_HY (kept pixels only) and S_OUT.
// So no new pixel is taken before the last one is done. The point beat shows on
// out_valid_o when S_OUT loads the output register. A finished point sits there while
// the next pixel is accepted and computed; when the receiver stalls, only the next
// point's final write-back waits for that register to free up. Reset clears the
// counters, the sequencer and out_valid_o, and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "depth_pixel_backprojection_unit_macros.svh"

module depth_pixel_backprojection_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   raw_depth_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    red_i,
  input  logic                          last_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            point_x_o,
  output logic signed [31:0]            point_y_o,
  output logic [31:0]                   point_z_o,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic [dpb_pkg::KeptW-1:0]     point_index_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dpb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_Z, S_ZCHK, S_PX, S_LX, S_HX, S_PY, S_LY, S_HY, S_OUT
  } state_e;

  localparam logic [dpb_pkg::KeptW-1:0] KeptTop = '1;
  localparam logic [dpb_pkg::RowW-1:0]  RowTop  = dpb_pkg::RowW'(dpb_pkg::MaxHeight - 1);

  function automatic logic [17:0] pixel_offset(input logic [11:0] pos, input logic [15:0] ctr);
    logic [17:0] diff;
    diff = {2'b00, pos, 4'b0000} - {2'b00, ctr};
    return diff;
  endfunction

  function automatic logic [16:0] offset_mag(input logic [17:0] diff);
    logic [17:0] m;
    m = diff[17] ? (18'd0 - diff) : diff;
    return m[16:0];
  endfunction

  function automatic logic [31:0] sat_axis(input logic neg, input logic [45:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag[45:31] != '0) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      r = (mag[45:31] != '0) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  dpb_pkg::cfg_t cfg;

  state_e state_q;
  logic [15:0] raw_q;
  logic [7:0]  blue_q, green_q, red_q;
  logic        last_q, keep_q;
  logic [31:0] z_q;
  logic [27:0] hi_q;
  logic [17:0] acc_q;
  logic [31:0] x_q, y_q;
  logic [dpb_pkg::PosW-1:0]  column_q;
  logic [dpb_pkg::RowW-1:0]  row_q;
  logic [dpb_pkg::KeptW-1:0] kept_q;

  logic        out_valid_q;
  logic [31:0] point_x_q, point_y_q, point_z_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q;
  logic [dpb_pkg::KeptW-1:0] point_index_q;

  logic [dpb_pkg::MulAW-1:0] mul_a;
  logic [dpb_pkg::MulBW-1:0] mul_b;
  logic [dpb_pkg::ProdW-1:0] prod;

  logic [17:0] dx, dy;
  logic [16:0] dx_mag, dy_mag;
  logic [31:0] z_new;
  logic        z_ok;
  logic [45:0] mag_sum;
  logic        in_take, finish, col_wrap, out_load;

  dpb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;

  assign dx     = pixel_offset(column_q, cfg.center_x);
  assign dy     = pixel_offset(row_q, cfg.center_y);
  assign dx_mag = offset_mag(dx);
  assign dy_mag = offset_mag(dy);

  assign z_new   = prod[39:8];
  assign z_ok    = (z_new > cfg.min_depth) && (z_new <= cfg.max_depth);
  // Exact product split: |d| * p / 2^28 = |d| * hi + floor(|d| * lo / 2^28).
  assign mag_sum = prod[45:0] + 46'(acc_q);

  // A rejected pixel does not need the output register.
  assign finish   = !keep_q || !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_OUT) && finish && keep_q;
  assign col_wrap = ({1'b0, column_q} + 13'd1) >= cfg.eff_width;

  always_comb begin
    unique case (state_q)
      S_Z: begin
        mul_a = 32'(raw_q);
        mul_b = 28'(cfg.recip_depth_scale);
      end
      S_ZCHK: begin
        mul_a = z_new;
        mul_b = 28'(cfg.recip_focal_x);
      end
      S_PX: begin
        mul_a = 32'(dx_mag);
        mul_b = prod[27:0];
      end
      S_LX: begin
        mul_a = 32'(dx_mag);
        mul_b = hi_q;
      end
      S_HX: begin
        mul_a = z_q;
        mul_b = 28'(cfg.recip_focal_y);
      end
      S_PY: begin
        mul_a = 32'(dy_mag);
        mul_b = prod[27:0];
      end
      S_LY: begin
        mul_a = 32'(dy_mag);
        mul_b = hi_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      column_q    <= '0;
      row_q       <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
      keep_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            raw_q   <= raw_depth_i;
            blue_q  <= blue_i;
            green_q <= green_i;
            red_q   <= red_i;
            last_q  <= last_pixel_i;
            state_q <= S_Z;
          end
        end
        S_Z: begin
          state_q <= S_ZCHK;
        end
        S_ZCHK: begin
          z_q     <= z_new;
          keep_q  <= z_ok;
          state_q <= z_ok ? S_PX : S_OUT;
        end
        S_PX: begin
          hi_q    <= prod[55:28];
          state_q <= S_LX;
        end
        S_LX: begin
          acc_q   <= prod[45:28];
          state_q <= S_HX;
        end
        S_HX: begin
          x_q     <= sat_axis(dx[17], mag_sum);
          state_q <= S_PY;
        end
        S_PY: begin
          hi_q    <= prod[55:28];
          state_q <= S_LY;
        end
        S_LY: begin
          acc_q   <= prod[45:28];
          state_q <= S_HY;
        end
        S_HY: begin
          y_q     <= sat_axis(dy[17], mag_sum);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (finish) begin
            if (keep_q) begin
              out_valid_q   <= 1'b1;
              point_x_q     <= x_q;
              point_y_q     <= y_q;
              point_z_q     <= z_q;
              out_red_q     <= red_q;
              out_green_q   <= green_q;
              out_blue_q    <= blue_q;
              point_index_q <= kept_q;
            end
            priority if (last_q) begin
              column_q <= '0;
              row_q    <= '0;
              kept_q   <= '0;
            end else begin
              if (keep_q && kept_q != KeptTop) begin
                kept_q <= kept_q + 1'b1;
              end
              if (col_wrap) begin
                column_q <= '0;
                if (row_q != RowTop) begin
                  row_q <= row_q + 1'b1;
                end
              end else begin
                column_q <= column_q + 1'b1;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = $signed(point_x_q);
  assign point_y_o     = $signed(point_y_q);
  assign point_z_o     = point_z_q;
  assign out_red_o     = out_red_q;
  assign out_green_o   = out_green_q;
  assign out_blue_o    = out_blue_q;
  assign point_index_o = point_index_q;

  `DPB_ASSERT_NEXT(a_take_starts, in_take, state_q == S_Z, "accepted pixel did not start")
  `DPB_ASSERT_NEXT(a_frame_clear, (state_q == S_OUT) && finish && last_q,
                   (column_q == '0) && (row_q == '0) && (kept_q == '0),
                   "counters not cleared after frame end")
  `DPB_ASSERT_NEXT(a_cnt_hold, !((state_q == S_OUT) && finish),
                   $stable(column_q) && $stable(row_q) && $stable(kept_q),
                   "counters moved outside pixel completion")
  `DPB_ASSERT_NOW(a_busy_stall, (state_q == S_PX) || (state_q == S_HY),
                  in_stall_o && keep_q, "projection running without a kept point")

endmodule

`default_nettype wire
